@@ rtl/rme_pkg.sv @@
// Shared widths, constants, the arctangent table and the angle finishing function.
package rme_pkg;

   localparam int SW  = 20;
   localparam int DW  = 19;
   localparam int PRW = 39;
   localparam int PW  = 41;
   localparam int NW  = PW - 1;
   localparam int AW  = 18;
   localparam int CW  = 17;
   localparam int QW  = 18;
   localparam int VW  = 33;
   localparam int ZW  = 26;
   localparam int XW  = 34;
   localparam int ANGW = 16;

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_CNT = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

   localparam int ARG_LAT    = 38;
   localparam int CORDIC_LAT = STEP_CNT + 6;
   localparam int TOT_LAT    = 3 + ARG_LAT + CORDIC_LAT;

   localparam logic signed [ZW-1:0] DEG90   = 26'sd5898240;
   localparam logic signed [ZW-1:0] DEG180  = 26'sd11796480;
   localparam logic signed [ZW-1:0] OUT_LIM = 26'sd23040;
   localparam logic signed [ZW-1:0] RND     = 26'sd128;

   localparam int ATAN_TAB [32] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0,
      0, 0, 0, 0, 0, 0, 0, 0
   };

   function automatic logic signed [ANGW-1:0] finish_angle(input logic signed [ZW-1:0] a);
      logic signed [ZW-1:0] f;
      logic signed [ZW-1:0] r;
      if (a > DEG90) begin
         f = DEG180 - a;
      end else if (a < -DEG90) begin
         f = -DEG180 - a;
      end else begin
         f = a;
      end
      r = (f + RND) >>> 8;
      if (r > OUT_LIM) begin
         r = OUT_LIM;
      end else if (r < -OUT_LIM) begin
         r = -OUT_LIM;
      end
      return r[ANGW-1:0];
   endfunction

endpackage

@@ rtl/rme_arg.sv @@
// Pipelined floor divider and square root that form the yaw sine and cosine operands.
module rme_arg import rme_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [PW-1:0] n,
   input  logic signed [SW-1:0] s,
   output logic signed [AW-1:0] a,
   output logic        [CW-1:0] c
);

   logic [NW-1:0] rem_ff [QW+1];
   logic [NW-1:0] rem_in [QW+1];
   logic [QW-1:0] q_ff   [QW+1];
   logic [QW-1:0] q_in   [QW+1];
   logic [SW-1:0] d_ff   [QW+1];
   logic          neg_ff [QW+1];
   logic          ovf_ff [QW+1];

   logic [NW-1:0] nm_in;
   logic [SW-1:0] d_in;
   logic          ovf_in;

   logic [QW:0]          qq;
   logic [CW-1:0]        mag_in;
   logic [CW-1:0]        mag_ff;
   logic signed [AW-1:0] afix_ff;
   logic signed [AW-1:0] afix_in;

   logic [VW-1:0]        srem_ff  [CW+1];
   logic [VW-1:0]        srem_in  [CW+1];
   logic [CW-1:0]        sroot_ff [CW+1];
   logic [CW-1:0]        sroot_in [CW+1];
   logic signed [AW-1:0] sa_ff    [CW+1];
   logic [VW+1:0]        trial;

   always_comb begin
      nm_in  = n[PW-1] ? NW'(-n) : NW'(n);
      d_in   = {s[SW-2:0], 1'b0};
      ovf_in = nm_in >= (NW'(d_in) << QW);
      rem_in[0] = nm_in;
      q_in[0]   = '0;
      for (int j = 0; j < QW; j++) begin
         rem_in[j+1] = rem_ff[j];
         q_in[j+1]   = q_ff[j];
         if (rem_ff[j] >= (NW'(d_ff[j]) << (QW - 1 - j))) begin
            rem_in[j+1] = rem_ff[j] - (NW'(d_ff[j]) << (QW - 1 - j));
            q_in[j+1][QW-1-j] = 1'b1;
         end
      end
      qq = {1'b0, q_ff[QW]} + (QW+1)'(neg_ff[QW] && (rem_ff[QW] != '0));
      if (ovf_ff[QW] || qq > (QW+1)'(65536)) begin
         mag_in = CW'(65536);
      end else begin
         mag_in = qq[CW-1:0];
      end
      afix_in = neg_ff[QW] ? -$signed({1'b0, mag_in}) : $signed({1'b0, mag_in});
      srem_in[0]  = (VW'(1) << 32) - (VW'(mag_ff) * VW'(mag_ff));
      sroot_in[0] = '0;
      trial = '0;
      for (int j = 0; j < CW; j++) begin
         srem_in[j+1]  = srem_ff[j];
         sroot_in[j+1] = sroot_ff[j];
         trial = ((VW+2)'(sroot_ff[j]) << (CW - j)) + ((VW+2)'(1) << (2 * (CW - 1 - j)));
         if ((VW+2)'(srem_ff[j]) >= trial) begin
            srem_in[j+1] = VW'((VW+2)'(srem_ff[j]) - trial);
            sroot_in[j+1][CW-1-j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         d_ff[0]   <= d_in;
         neg_ff[0] <= n[PW-1];
         ovf_ff[0] <= ovf_in;
         for (int j = 0; j < QW; j++) begin
            rem_ff[j+1] <= rem_in[j+1];
            q_ff[j+1]   <= q_in[j+1];
            d_ff[j+1]   <= d_ff[j];
            neg_ff[j+1] <= neg_ff[j];
            ovf_ff[j+1] <= ovf_ff[j];
         end
         mag_ff  <= mag_in;
         afix_ff <= afix_in;
         srem_ff[0]  <= srem_in[0];
         sroot_ff[0] <= sroot_in[0];
         sa_ff[0]    <= afix_ff;
         for (int j = 0; j < CW; j++) begin
            srem_ff[j+1]  <= srem_in[j+1];
            sroot_ff[j+1] <= sroot_in[j+1];
            sa_ff[j+1]    <= sa_ff[j];
         end
      end
   end

   assign a = sa_ff[CW];
   assign c = sroot_ff[CW];

endmodule

@@ rtl/rme_cordic.sv @@
// Pipelined vectoring CORDIC that turns a vector into a folded, rounded angle.
module rme_cordic import rme_pkg::*; (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [PW-1:0]   x,
   input  logic signed [PW-1:0]   y,
   output logic signed [ANGW-1:0] angle
);

   typedef struct packed {
      logic xneg;
      logic yneg;
      logic zero;
   } quad_type;

   quad_type flag_ff [CORDIC_LAT-1];

   logic [PW-1:0] ax_ff, ay_ff, n1x_ff, n1y_ff, n1x_in, n1y_in;
   logic [29:0]   n2x_ff, n2y_ff, n2x_in, n2y_in;
   logic [29:0]   n3x_ff, n3y_ff, n3x_in, n3y_in;
   logic [29:0]   n4x_in, n4y_in;
   logic [PW-1:0] tx, ty;
   logic [29:0]   ux, uy;

   logic signed [XW-1:0] cx_ff [STEP_CNT+1];
   logic signed [XW-1:0] cy_ff [STEP_CNT+1];
   logic signed [ZW-1:0] z_ff  [STEP_CNT+1];
   logic signed [XW-1:0] cx_in [STEP_CNT+1];
   logic signed [XW-1:0] cy_in [STEP_CNT+1];
   logic signed [ZW-1:0] z_in  [STEP_CNT+1];

   logic signed [ZW-1:0]   zf;
   logic signed [ANGW-1:0] angle_ff;

   always_comb begin
      tx = ax_ff;
      ty = ay_ff;
      if (((tx | ty) >> 37) != '0) begin
         tx = tx >> 8;
         ty = ty >> 8;
      end
      if (((tx | ty) >> 33) != '0) begin
         tx = tx >> 4;
         ty = ty >> 4;
      end
      n1x_in = tx;
      n1y_in = ty;
      tx = n1x_ff;
      ty = n1y_ff;
      if (((tx | ty) >> 31) != '0) begin
         tx = tx >> 2;
         ty = ty >> 2;
      end
      if (((tx | ty) >> 30) != '0) begin
         tx = tx >> 1;
         ty = ty >> 1;
      end
      n2x_in = tx[29:0];
      n2y_in = ty[29:0];
      ux = n2x_ff;
      uy = n2y_ff;
      if (((ux | uy) >> 14) == '0) begin
         ux = ux << 16;
         uy = uy << 16;
      end
      if (((ux | uy) >> 22) == '0) begin
         ux = ux << 8;
         uy = uy << 8;
      end
      n3x_in = ux;
      n3y_in = uy;
      ux = n3x_ff;
      uy = n3y_ff;
      if (((ux | uy) >> 26) == '0) begin
         ux = ux << 4;
         uy = uy << 4;
      end
      if (((ux | uy) >> 28) == '0) begin
         ux = ux << 2;
         uy = uy << 2;
      end
      if (((ux | uy) >> 29) == '0) begin
         ux = ux << 1;
         uy = uy << 1;
      end
      n4x_in = ux;
      n4y_in = uy;
      cx_in[0] = $signed(XW'(n4x_in));
      cy_in[0] = $signed(XW'(n4y_in));
      z_in[0]  = '0;
      for (int i = 0; i < STEP_CNT; i++) begin
         if (cy_ff[i] >= 0) begin
            cx_in[i+1] = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] - (cx_ff[i] >>> i);
            z_in[i+1]  = z_ff[i] + ZW'(ATAN_TAB[i]);
         end else begin
            cx_in[i+1] = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] + (cx_ff[i] >>> i);
            z_in[i+1]  = z_ff[i] - ZW'(ATAN_TAB[i]);
         end
      end
      zf = z_ff[STEP_CNT];
      if (flag_ff[CORDIC_LAT-2].xneg) begin
         zf = DEG180 - zf;
      end
      if (flag_ff[CORDIC_LAT-2].yneg) begin
         zf = -zf;
      end
      if (flag_ff[CORDIC_LAT-2].zero) begin
         zf = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= x[PW-1] ? PW'(-x) : PW'(x);
         ay_ff <= y[PW-1] ? PW'(-y) : PW'(y);
         flag_ff[0] <= '{xneg: x[PW-1], yneg: y[PW-1], zero: (x == '0) && (y == '0)};
         for (int k = 1; k < CORDIC_LAT - 1; k++) begin
            flag_ff[k] <= flag_ff[k-1];
         end
         n1x_ff <= n1x_in;
         n1y_ff <= n1y_in;
         n2x_ff <= n2x_in;
         n2y_ff <= n2y_in;
         n3x_ff <= n3x_in;
         n3y_ff <= n3y_in;
         for (int i = 0; i <= STEP_CNT; i++) begin
            cx_ff[i] <= cx_in[i];
            cy_ff[i] <= cy_in[i];
            z_ff[i]  <= z_in[i];
         end
         angle_ff <= finish_angle(zf);
      end
   end

   assign angle = angle_ff;

endmodule

@@ rtl/rotation_matrix_to_euler_core.sv @@
// Top level: matrix front end, yaw operand path, three CORDIC units and output buffer.
// Rotation matrix to Euler angles. One matrix word per cycle is taken while the output
// buffer is not full; each word passes TOT_LAT stages (3 front stages, bit-per-stage
// division and square root, then CORDIC_STEPS plus 6 CORDIC stages) in a pipeline
// that advances as a whole, and a two-word output buffer lets input flow
// while a result waits. A degenerate matrix (one plus trace not positive) returns
// zero angles with tuser set.
module rotation_matrix_to_euler_core import rme_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [167:0] req_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,  // yaw_deg, pitch_deg, roll_deg
   output logic         rsp_tuser   // degenerate
);

   typedef struct packed {
      logic signed [PW-1:0] py;
      logic signed [PW-1:0] px;
      logic signed [PW-1:0] ry;
      logic signed [PW-1:0] rx;
   } pr_type;

   logic signed [17:0] m [9];
   logic               en;
   logic [TOT_LAT-1:0] vld_ff;
   logic [TOT_LAT-1:0] dg_ff;

   logic signed [SW-1:0] s_in, s1_ff, s2_ff, s3_ff;
   logic signed [DW-1:0] d1_ff, d2_ff, d3_ff;
   logic signed [PRW-1:0] ss_ff, sd1_ff, sd2_ff, sd3_ff, d11_ff, d22_ff, d33_ff;
   logic signed [PRW-1:0] d12_ff, d13_ff, d23_ff;
   logic signed [PW-1:0] n_ff;
   pr_type               pr_in;
   pr_type               pr_ff [ARG_LAT+1];

   logic signed [AW-1:0]   ya;
   logic        [CW-1:0]   yc;
   logic signed [ANGW-1:0] yaw, pitch, roll;

   logic [1:0]  cnt_ff;
   logic [48:0] head_ff, tail_ff, new_word;
   logic        push, pop;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         m[i] = $signed(req_tdata[18*i +: 18]);
      end
      s_in = 20'sd65536 + SW'(m[0]) + SW'(m[4]) + SW'(m[8]);
      pr_in.py = PW'(sd1_ff - d23_ff) <<< 1;
      pr_in.px = PW'(ss_ff) - PW'(d11_ff) - PW'(d22_ff) + PW'(d33_ff);
      pr_in.ry = PW'(sd3_ff - d12_ff) <<< 1;
      pr_in.rx = PW'(ss_ff) + PW'(d11_ff) - PW'(d22_ff) - PW'(d33_ff);
   end

   assign en         = cnt_ff != 2'd2;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOT_LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dg_ff  <= {dg_ff[TOT_LAT-2:0], s_in <= 0};
         s1_ff  <= s_in;
         d1_ff  <= DW'(m[7]) - DW'(m[5]);
         d2_ff  <= DW'(m[2]) - DW'(m[6]);
         d3_ff  <= DW'(m[3]) - DW'(m[1]);
         s2_ff  <= s1_ff;
         ss_ff  <= PRW'(s1_ff) * PRW'(s1_ff);
         sd1_ff <= PRW'(s1_ff) * PRW'(d1_ff);
         sd2_ff <= PRW'(s1_ff) * PRW'(d2_ff);
         sd3_ff <= PRW'(s1_ff) * PRW'(d3_ff);
         d11_ff <= PRW'(d1_ff) * PRW'(d1_ff);
         d22_ff <= PRW'(d2_ff) * PRW'(d2_ff);
         d33_ff <= PRW'(d3_ff) * PRW'(d3_ff);
         d12_ff <= PRW'(d1_ff) * PRW'(d2_ff);
         d13_ff <= PRW'(d1_ff) * PRW'(d3_ff);
         d23_ff <= PRW'(d2_ff) * PRW'(d3_ff);
         s3_ff  <= s2_ff;
         n_ff   <= PW'(sd2_ff) + PW'(d13_ff);
         pr_ff[0] <= pr_in;
         for (int k = 1; k <= ARG_LAT; k++) begin
            pr_ff[k] <= pr_ff[k-1];
         end
      end
   end

   rme_arg u_arg (
      .clock (clock),
      .en    (en),
      .n     (n_ff),
      .s     (s3_ff),
      .a     (ya),
      .c     (yc)
   );

   rme_cordic u_yaw (
      .clock (clock),
      .en    (en),
      .x     ($signed(PW'(yc))),
      .y     (PW'(ya)),
      .angle (yaw)
   );

   rme_cordic u_pitch (
      .clock (clock),
      .en    (en),
      .x     (pr_ff[ARG_LAT].px),
      .y     (pr_ff[ARG_LAT].py),
      .angle (pitch)
   );

   rme_cordic u_roll (
      .clock (clock),
      .en    (en),
      .x     (pr_ff[ARG_LAT].rx),
      .y     (pr_ff[ARG_LAT].ry),
      .angle (roll)
   );

   assign push     = en && vld_ff[TOT_LAT-1];
   assign pop      = rsp_tvalid && rsp_tready;
   assign new_word = dg_ff[TOT_LAT-1] ? {1'b1, 48'd0} : {1'b0, roll, pitch, yaw};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop))) begin
         head_ff <= new_word;
      end else if (pop && cnt_ff == 2'd2) begin
         head_ff <= tail_ff;
      end
      if (push && cnt_ff == 2'd1 && !pop) begin
         tail_ff <= new_word;
      end
   end

   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tdata  = head_ff[47:0];
   assign rsp_tuser  = head_ff[48];

endmodule

@@ rtl/rme_checker.sv @@
// Port checker for the Euler angle core and its bind statement.
module rme_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled result word holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // A degenerate matrix gives zero angles.
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 48'd0)
      else $error("degenerate word with nonzero angles");

   // All angles lie within plus or minus ninety degrees.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16'sd23040)
         && ($signed(rsp_tdata[15:0]) >= -16'sd23040)
         && ($signed(rsp_tdata[31:16]) <= 16'sd23040)
         && ($signed(rsp_tdata[31:16]) >= -16'sd23040)
         && ($signed(rsp_tdata[47:32]) <= 16'sd23040)
         && ($signed(rsp_tdata[47:32]) >= -16'sd23040))
      else $error("angle out of range");

   // With the output buffer empty the block must take input.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule

bind rotation_matrix_to_euler_core rme_checker u_checker (.*);

@@ test/tb_rotation_matrix_to_euler_core.sv @@
// Testbench for rotation_matrix_to_euler_core: random and directed matrices checked against a predictor.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_euler_core;
   import rme_pkg::*;

   localparam longint DEG_90  = 64'sd5898240;
   localparam longint DEG_180 = 64'sd11796480;
   localparam int     CYCLE_LIMIT = 400000;
   localparam int     RANDOM_WORDS = 1350;

   typedef struct packed {
      logic [15:0] yaw;
      logic [15:0] pitch;
      logic [15:0] roll;
      logic        degenerate;
   } euler_type;

   function automatic longint elem(input logic [167:0] d, input int k);
      logic signed [17:0] v;
      v = d[18*k +: 18];
      return longint'(v);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic longint vector_angle(input longint y, input longint x);
      longint unsigned ax;
      longint unsigned ay;
      longint cx, cy, nx, ny, z;
      ax = (x < 0) ? longint'(-x) : longint'(x);
      ay = (y < 0) ? longint'(-y) : longint'(y);
      z = 0;
      if (ax == 0 && ay == 0) return 0;
      while ((ax | ay) >= (64'd1 << 30)) begin
         ax = ax >> 1;
         ay = ay >> 1;
      end
      while ((ax | ay) < (64'd1 << 29)) begin
         ax = ax << 1;
         ay = ay << 1;
      end
      cx = longint'(ax);
      cy = longint'(ay);
      for (int i = 0; i < STEP_CNT; i++) begin
         if (cy >= 0) begin
            nx = cx + (cy >>> i);
            ny = cy - (cx >>> i);
            z = z + ATAN_TAB[i];
         end else begin
            nx = cx - (cy >>> i);
            ny = cy + (cx >>> i);
            z = z - ATAN_TAB[i];
         end
         cx = nx;
         cy = ny;
      end
      if (x < 0) z = DEG_180 - z;
      if (y < 0) z = -z;
      return z;
   endfunction

   function automatic logic [15:0] fold_round(input longint a);
      longint r;
      if (a > DEG_90) a = DEG_180 - a;
      else if (a < -DEG_90) a = -DEG_180 - a;
      r = (a + 128) >>> 8;
      if (r > 23040) r = 23040;
      if (r < -23040) r = -23040;
      return r[15:0];
   endfunction

   function automatic euler_type predict_angles(input logic [167:0] d);
      euler_type e;
      longint s, d1, d2, d3, num, den, a;
      longint unsigned c;
      e = '0;
      s = 65536 + elem(d, 0) + elem(d, 4) + elem(d, 8);
      if (s <= 0) begin
         e.degenerate = 1'b1;
         return e;
      end
      d1 = elem(d, 7) - elem(d, 5);
      d2 = elem(d, 2) - elem(d, 6);
      d3 = elem(d, 3) - elem(d, 1);
      num = s * d2 + d1 * d3;
      den = 2 * s;
      if (num >= 0) a = num / den;
      else a = -((-num + den - 1) / den);
      if (a > 65536) a = 65536;
      if (a < -65536) a = -65536;
      c = int_sqrt((64'd1 << 32) - longint'(a * a));
      e.yaw = fold_round(vector_angle(a, longint'(c)));
      e.pitch = fold_round(vector_angle(2 * (s * d1 - d2 * d3),
                                        s * s - d1 * d1 - d2 * d2 + d3 * d3));
      e.roll = fold_round(vector_angle(2 * (s * d3 - d1 * d2),
                                       s * s + d1 * d1 - d2 * d2 - d3 * d3));
      return e;
   endfunction

   class scoreboard_type;
      euler_type expected_q[$];
      int errors;
      int accepted;

      function void note_matrix(input logic [167:0] d);
         expected_q = {expected_q, predict_angles(d)};
         accepted++;
      endfunction

      function void check_angles(input logic [47:0] d, input logic u);
         euler_type want;
         euler_type got;
         got = {d[15:0], d[31:16], d[47:32], u};
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result word: %h tuser %b", d, u);
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("Mismatch: expected yaw %h pitch %h roll %h degen %b, got %h %h %h %b",
                        want.yaw, want.pitch, want.roll, want.degenerate,
                        got.yaw, got.pitch, got.roll, got.degenerate);
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [167:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [47:0]  rsp_tdata;
   logic         rsp_tuser;

   scoreboard_type board;
   int cycles;
   bit held_off;

   rotation_matrix_to_euler_core DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [167:0] pack_matrix(input longint m [9]);
      logic [167:0] d;
      d = '0;
      for (int k = 0; k < 9; k++) d[18*k +: 18] = m[k][17:0];
      return d;
   endfunction

   function automatic longint to_q16(input real v);
      return longint'($rtoi(v * 65536.0 + ((v >= 0.0) ? 0.5 : -0.5)));
   endfunction

   function automatic logic [167:0] rotation_word(input real yw, input real pt, input real rl);
      longint m [9];
      real cy, sy, cp, sp, cr, sr;
      cy = $cos(yw); sy = $sin(yw);
      cp = $cos(pt); sp = $sin(pt);
      cr = $cos(rl); sr = $sin(rl);
      m[0] = to_q16(cy * cp);
      m[1] = to_q16(cy * sp * sr - sy * cr);
      m[2] = to_q16(cy * sp * cr + sy * sr);
      m[3] = to_q16(sy * cp);
      m[4] = to_q16(sy * sp * sr + cy * cr);
      m[5] = to_q16(sy * sp * cr - cy * sr);
      m[6] = to_q16(-sp);
      m[7] = to_q16(cp * sr);
      m[8] = to_q16(cp * cr);
      return pack_matrix(m);
   endfunction

   function automatic real rand_angle();
      return ($itor($urandom_range(0, 2000000)) / 1000000.0 - 1.0) * 3.14159265358979;
   endfunction

   function automatic logic [167:0] random_matrix();
      logic [167:0] d;
      int kind;
      kind = $urandom_range(0, 99);
      d = '0;
      if (kind < 60) begin
         d = rotation_word(rand_angle(), rand_angle(), rand_angle());
      end else if (kind < 72) begin
         d = rotation_word(rand_angle(), 3.14159265358979 * (($urandom_range(0, 1) == 1) ?
                           0.5 : -0.5), rand_angle());
      end else if (kind < 85) begin
         d = rotation_word(rand_angle(), rand_angle(), rand_angle());
         for (int k = 0; k < 9; k++)
            d[18*k +: 18] = d[18*k +: 18] + 18'($urandom_range(0, 64)) - 18'd32;
      end else if (kind < 93) begin
         for (int k = 0; k < 9; k++) d[18*k +: 18] = 18'($urandom_range(0, 262143));
      end else begin
         for (int k = 0; k < 9; k++)
            d[18*k +: 18] = 18'($urandom_range(0, 131072)) - 18'd65536;
      end
      return d;
   endfunction

   task automatic send_word(input logic [167:0] d);
      req_tdata <= d;
      req_tvalid <= 1'b1;
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      board.note_matrix(d);
      @(posedge clock);
   endtask

   task automatic send_burst_list(input logic [167:0] words [$]);
      int gap;
      foreach (words[i]) begin
         send_word(words[i]);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic run_random(input int count);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_word(random_matrix());
            sent++;
         end
         gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   function automatic logic [167:0] uniform_word(input longint v);
      longint m [9];
      foreach (m[k]) m[k] = v;
      return pack_matrix(m);
   endfunction

   function automatic logic [167:0] diag_word(input longint a, input longint b, input longint c,
                                               input longint m02, input longint m20);
      longint m [9];
      foreach (m[k]) m[k] = 0;
      m[0] = a; m[4] = b; m[8] = c; m[2] = m02; m[6] = m20;
      return pack_matrix(m);
   endfunction

   initial begin
      logic [167:0] directed [$];
      real hp;
      hp = 3.14159265358979 / 2.0;
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed = {directed, diag_word(65536, 65536, 65536, 0, 0)};
      directed = {directed, uniform_word(0)};
      directed = {directed, uniform_word(65536)};
      directed = {directed, uniform_word(-65536)};
      directed = {directed, uniform_word(131071)};
      directed = {directed, uniform_word(-131072)};
      directed = {directed, diag_word(65536, -65536, -65536, 0, 0)};
      directed = {directed, diag_word(-21845, -21845, -21846, 0, 0)};
      directed = {directed, diag_word(-21845, -21845, -21845, 0, 0)};
      directed = {directed, diag_word(-21845, -21845, -21845, 65536, -65536)};
      directed = {directed, diag_word(-21845, -21845, -21845, -65536, 65536)};
      directed = {directed, diag_word(-131072, 131071, 131071, 131071, -131072)};
      directed = {directed, rotation_word(hp, 0.0, 0.0)};
      directed = {directed, rotation_word(0.0, hp, 0.0)};
      directed = {directed, rotation_word(0.0, -hp, 0.0)};
      directed = {directed, rotation_word(0.0, 0.0, hp)};
      directed = {directed, rotation_word(0.0, 0.0, -hp)};
      directed = {directed, rotation_word(2.5, 0.3, -2.8)};
      directed = {directed, rotation_word(-3.0, 1.2, 3.0)};
      directed = {directed, rotation_word(0.7, -0.4, 0.2)};
      send_burst_list(directed);
      run_random(RANDOM_WORDS);
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (TOT_LAT + 20) @(posedge clock);
      if (board.errors == 0 && board.expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      int mode;
      int phase;
      rsp_tready = 1'b0;
      held_off = 1'b0;
      mode = 0;
      phase = 0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (!held_off && board.accepted >= 300) begin
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
            held_off = 1'b1;
         end else begin
            if (phase % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (phase % 3 != 0);
               default: rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
            phase++;
            @(posedge clock);
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_angles(rsp_tdata, rsp_tuser);
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

endmodule
